FILE: hw/rtl/u16u8_pkg.sv
// shared types, constants and byte encoder for the utf-16 to utf-8 transcoder
`default_nettype none
package u16u8_pkg;

	localparam int unsigned CuWidth    = 16;
	localparam int unsigned CpWidth    = 21;
	localparam int unsigned HeldWidth  = 10;
	localparam int unsigned LenWidth   = 3;
	localparam int unsigned FifoDepth  = 4;
	localparam int unsigned PtrWidth   = $clog2(FifoDepth);
	localparam int unsigned CntWidth   = $clog2(FifoDepth + 1);

	// surrogate range tags on the top six bits of a code unit
	localparam logic [5:0] HighTag = 6'b110110;
	localparam logic [5:0] LowTag  = 6'b110111;

	// byte counts of one sequence
	localparam logic [LenWidth-1:0] LenNone  = 3'd0;
	localparam logic [LenWidth-1:0] LenOne   = 3'd1;
	localparam logic [LenWidth-1:0] LenTwo   = 3'd2;
	localparam logic [LenWidth-1:0] LenThree = 3'd3;
	localparam logic [LenWidth-1:0] LenFour  = 3'd4;

	// one queued command: optional flush of a held high surrogate, then a main code point
	typedef struct packed {
		logic                 pre_en;
		logic [HeldWidth-1:0] pre_bits;
		logic [LenWidth-1:0]  main_len;
		logic [CpWidth-1:0]   main_cp;
		logic                 main_eos;
	} cmd_t;

	// byte k of the len-byte utf-8 sequence of cp
	function automatic logic [7:0] encode_byte(input logic [CpWidth-1:0] cp,
			input logic [LenWidth-1:0] len, input logic [1:0] k);
		logic [7:0] b;
		b = 8'h00;
		unique case (len)
			LenTwo: begin
				if (k == 2'd0) b = {3'b110, cp[10:6]};
				else           b = {2'b10, cp[5:0]};
			end
			LenThree: begin
				case (k)
					2'd0:    b = {4'b1110, cp[15:12]};
					2'd1:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			LenFour: begin
				case (k)
					2'd0:    b = {5'b11110, cp[20:18]};
					2'd1:    b = {2'b10, cp[17:12]};
					2'd2:    b = {2'b10, cp[11:6]};
					default: b = {2'b10, cp[5:0]};
				endcase
			end
			default: b = {1'b0, cp[6:0]};
		endcase
		return b;
	endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/u16u8_front.sv
// front end: classifies code units, pairs surrogates, builds commands
`default_nettype none
module u16u8_front (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           in_valid,
	input  wire logic [u16u8_pkg::CuWidth-1:0]  code_unit,
	input  wire logic                           full,
	output logic                                in_ready,
	output logic                                push,
	output u16u8_pkg::cmd_t                     cmd
);

	logic                               held_valid_q;
	logic [u16u8_pkg::HeldWidth-1:0]    held_bits_q;
	logic                               is_high;
	logic                               is_low;
	logic                               pair;
	logic                               accept;

	assign in_ready = !full;
	assign accept   = in_valid && !full;
	assign is_high  = (code_unit[15:10] == u16u8_pkg::HighTag);
	assign is_low   = (code_unit[15:10] == u16u8_pkg::LowTag);
	assign pair     = held_valid_q && is_low;

	// command build
	always_comb begin
		cmd          = '0;
		cmd.pre_bits = held_bits_q;
		cmd.main_eos = (code_unit == '0);
		if (pair) begin
			cmd.main_len = u16u8_pkg::LenFour;
			cmd.main_cp  = {1'b0, held_bits_q, code_unit[9:0]} + 21'h10000;
		end else begin
			cmd.pre_en  = held_valid_q;
			cmd.main_cp = {5'd0, code_unit};
			if (is_high)                 cmd.main_len = u16u8_pkg::LenNone;
			else if (code_unit < 16'h80)  cmd.main_len = u16u8_pkg::LenOne;
			else if (code_unit < 16'h800) cmd.main_len = u16u8_pkg::LenTwo;
			else                          cmd.main_len = u16u8_pkg::LenThree;
		end
		push = accept && (cmd.pre_en || (cmd.main_len != u16u8_pkg::LenNone));
	end

	// held high surrogate
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_valid_q <= 1'b0;
			held_bits_q  <= '0;
		end else if (accept) begin
			held_valid_q <= is_high && !pair;
			held_bits_q  <= (is_high && !pair) ? code_unit[9:0] : '0;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/u16u8_cmd_fifo.sv
// small command queue between front and back
`default_nettype none
module u16u8_cmd_fifo (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push,
	input  wire u16u8_pkg::cmd_t wr_cmd,
	input  wire logic            pop,
	output u16u8_pkg::cmd_t      rd_cmd,
	output logic                 empty,
	output logic                 full
);

	u16u8_pkg::cmd_t                    mem_q [u16u8_pkg::FifoDepth];
	logic [u16u8_pkg::PtrWidth-1:0]     wr_ptr_q;
	logic [u16u8_pkg::PtrWidth-1:0]     rd_ptr_q;
	logic [u16u8_pkg::CntWidth-1:0]     count_q;
	logic                               do_push;
	logic                               do_pop;

	assign empty   = (count_q == '0);
	assign full    = (count_q == u16u8_pkg::CntWidth'(u16u8_pkg::FifoDepth));
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rd_cmd  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wr_cmd;
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule
`default_nettype wire

FILE: hw/rtl/u16u8_back.sv
// back end: serializes to utf-8 bytes, one per cycle unless stalled
`default_nettype none
module u16u8_back (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire u16u8_pkg::cmd_t cmd,
	input  wire logic            empty,
	output logic                 pop,
	output logic                 out_valid,
	input  wire logic            out_ready,
	output logic [7:0]           out_byte,
	output logic                 last_of_run,
	output logic                 end_of_string
);

	logic [u16u8_pkg::LenWidth-1:0] idx_q;
	logic [u16u8_pkg::LenWidth-1:0] total;
	logic [u16u8_pkg::LenWidth-1:0] sub;
	logic                           in_pre;
	logic                           is_last;
	logic                           advance;
	logic [7:0]                     cur_byte;
	logic                           valid_q;
	logic [7:0]                     byte_q;
	logic                           last_q;
	logic                           eos_q;

	// byte selection for the current position
	always_comb begin
		total    = cmd.pre_en ? (cmd.main_len + u16u8_pkg::LenThree) : cmd.main_len;
		in_pre   = cmd.pre_en && (idx_q < u16u8_pkg::LenThree);
		sub      = cmd.pre_en ? (idx_q - u16u8_pkg::LenThree) : idx_q;
		if (in_pre)
			cur_byte = u16u8_pkg::encode_byte({5'd0, u16u8_pkg::HighTag, cmd.pre_bits},
				u16u8_pkg::LenThree, idx_q[1:0]);
		else
			cur_byte = u16u8_pkg::encode_byte(cmd.main_cp, cmd.main_len, sub[1:0]);
		is_last  = (idx_q == total - 1'b1);
		advance  = !empty && (!valid_q || out_ready);
		pop      = advance && is_last;
	end

	// position within the command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)      idx_q <= '0;
		else if (advance) idx_q <= is_last ? '0 : idx_q + 1'b1;
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                  valid_q <= 1'b0;
		else if (!valid_q || out_ready) valid_q <= !empty;
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			byte_q <= cur_byte;
			last_q <= is_last;
			eos_q  <= is_last && cmd.main_eos;
		end
	end

	assign out_valid     = valid_q;
	assign out_byte      = byte_q;
	assign last_of_run   = last_q;
	assign end_of_string = eos_q;

endmodule
`default_nettype wire

FILE: hw/rtl/utf16_to_utf8_stream.sv
// utf16_to_utf8_stream: one utf-16 code unit in, utf-8 bytes out
// an item's first byte passes through the command queue and then the output register,
//   and waits behind the bytes of earlier items that are still in the queue
// throughput: one output byte per cycle unless stalled; an item gives 1 to 6 bytes,
//   set by the byte serializer; a stored high surrogate gives no byte and is not
//   queued
// a four-entry command queue lets input run ahead of output
// reset: arst_n clears the held surrogate, the queue and the output valid
`default_nettype none
module utf16_to_utf8_stream (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // [15:0] code_unit
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [7:0]       m_axis_tdata,  // [7:0] out_byte
	output logic             m_axis_tlast,  // last_of_run
	output logic             m_axis_tuser   // [0] end_of_string
);

	u16u8_pkg::cmd_t wr_cmd;
	u16u8_pkg::cmd_t rd_cmd;
	logic            push;
	logic            pop;
	logic            empty;
	logic            full;

	// classification and surrogate pairing
	u16u8_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.code_unit (s_axis_tdata),
		.full      (full),
		.in_ready  (s_axis_tready),
		.push      (push),
		.cmd       (wr_cmd)
	);

	// command queue
	u16u8_cmd_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wr_cmd (wr_cmd),
		.pop    (pop),
		.rd_cmd (rd_cmd),
		.empty  (empty),
		.full   (full)
	);

	// byte serializer
	u16u8_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (rd_cmd),
		.empty         (empty),
		.pop           (pop),
		.out_valid     (m_axis_tvalid),
		.out_ready     (m_axis_tready),
		.out_byte      (m_axis_tdata),
		.last_of_run   (m_axis_tlast),
		.end_of_string (m_axis_tuser)
	);

endmodule
`default_nettype wire

FILE: hw/rtl/u16u8_checker.sv
// port-level checks for the transcoder, bound to the top level
`default_nettype none
module u16u8_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic       m_axis_tlast,
	input wire logic       m_axis_tuser
);

	// end of string is a zero byte closing its run
	a_eos_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == 8'h00))
		else $error("end of string on a nonzero or non-final byte");

	// a lead byte never closes a run
	a_lead_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tdata[7:6] == 2'b11) |-> !m_axis_tlast)
		else $error("multi-byte lead closes a run");

	// no lead byte beyond the unicode range
	a_byte_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> (m_axis_tdata < 8'hF5))
		else $error("invalid utf-8 byte value");

	// a stalled word holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("output word changed under stall");

endmodule

bind utf16_to_utf8_stream u16u8_checker u_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tlast  (m_axis_tlast),
	.m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

FILE: verif/utf16_to_utf8_stream_tb.sv
// testbench for the utf-16 to utf-8 stream transcoder with its own byte predictor
module utf16_to_utf8_stream_tb;

	localparam int CycleLimit   = 200000;
	localparam int StallCycles  = 300;
	localparam int DrainCycles  = 12;

	// one expected output word
	typedef struct packed {
		logic [7:0] data;
		logic       last;
		logic       eos;
	} utf8_word_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata;  // [15:0] code_unit
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [7:0]  m_axis_tdata;  // [7:0] out_byte
	logic        m_axis_tlast;  // last_of_run
	logic        m_axis_tuser;  // [0] end_of_string

	utf8_word_t  utf8_expected[$];
	utf8_word_t  want;
	logic [9:0]  held_bits;
	logic        held_ok;
	int          send_idle_pct;
	int          recv_idle_pct;
	int          fail_count;
	int          cycle_count;
	bit          hold_start;
	bit          hold_active;

	utf16_to_utf8_stream i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// run length guard
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CycleLimit) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic void push_word(input logic [7:0] b, input logic eos);
		utf8_word_t w;
		w.data = b;
		w.last = 1'b0;
		w.eos  = eos;
		utf8_expected.push_back(w);
	endfunction

	// utf-8 bytes of one code point
	function automatic void encode_point(input logic [20:0] cp);
		if (cp < 21'h80) begin
			push_word(cp[7:0], 1'b0);
		end else if (cp < 21'h800) begin
			push_word({3'b110, cp[10:6]}, 1'b0);
			push_word({2'b10, cp[5:0]}, 1'b0);
		end else if (cp < 21'h10000) begin
			push_word({4'b1110, cp[15:12]}, 1'b0);
			push_word({2'b10, cp[11:6]}, 1'b0);
			push_word({2'b10, cp[5:0]}, 1'b0);
		end else begin
			push_word({5'b11110, cp[20:18]}, 1'b0);
			push_word({2'b10, cp[17:12]}, 1'b0);
			push_word({2'b10, cp[11:6]}, 1'b0);
			push_word({2'b10, cp[5:0]}, 1'b0);
		end
	endfunction

	// expected words for one accepted code unit
	function automatic void predict_unit(input logic [15:0] cu);
		int         start_size;
		logic [20:0] cp;
		utf8_word_t w;
		start_size = utf8_expected.size();
		if (held_ok) begin
			if (cu[15:10] == u16u8_pkg::LowTag) begin
				// surrogate pair becomes one supplementary code point
				cp = {1'b0, held_bits, cu[9:0]} + 21'h10000;
				held_ok   = 1'b0;
				held_bits = '0;
				encode_point(cp);
			end else begin
				// unpaired high surrogate goes out on its own
				encode_point({5'b0, u16u8_pkg::HighTag, held_bits});
				held_ok   = 1'b0;
				held_bits = '0;
				if (cu == 16'h0000) begin
					push_word(8'h00, 1'b1);
				end else if (cu[15:10] == u16u8_pkg::HighTag) begin
					held_bits = cu[9:0];
					held_ok   = 1'b1;
				end else begin
					encode_point({5'b0, cu});
				end
			end
		end else if (cu == 16'h0000) begin
			push_word(8'h00, 1'b1);
		end else if (cu[15:10] == u16u8_pkg::HighTag) begin
			held_bits = cu[9:0];
			held_ok   = 1'b1;
		end else begin
			encode_point({5'b0, cu});
		end
		// mark the final word of this unit
		if (utf8_expected.size() > start_size) begin
			w = utf8_expected.pop_back();
			w.last = 1'b1;
			utf8_expected.push_back(w);
		end
	endfunction

	// ---------------------------------------------------------------- receiver side

	// long hold-off on the output, counted in its own process
	initial begin
		hold_active = 1'b0;
		forever begin
			wait (hold_start);
			hold_start  = 1'b0;
			hold_active = 1'b1;
			repeat (StallCycles) @(posedge clk);
			hold_active = 1'b0;
		end
	end

	// output ready with random stalls
	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= !hold_active && ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// compare each accepted word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (utf8_expected.size() == 0) begin
				$error("unexpected word: out_byte %h last %b eos %b",
					m_axis_tdata, m_axis_tlast, m_axis_tuser);
				fail_count++;
			end else begin
				want = utf8_expected.pop_front();
				if (m_axis_tdata !== want.data) begin
					$error("out_byte: expected %h, got %h", want.data, m_axis_tdata);
					fail_count++;
				end
				if (m_axis_tlast !== want.last) begin
					$error("last_of_run: expected %b, got %b", want.last, m_axis_tlast);
					fail_count++;
				end
				if (m_axis_tuser !== want.eos) begin
					$error("end_of_string: expected %b, got %b", want.eos, m_axis_tuser);
					fail_count++;
				end
			end
		end
	end

	// ---------------------------------------------------------------- sender side

	// offer one code unit, starting and ending at a falling edge
	task automatic send_unit(input logic [15:0] cu);
		while ($urandom_range(99) < send_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= 16'($urandom);
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= cu;
		do @(posedge clk); while (!s_axis_tready);
		predict_unit(cu);
		@(negedge clk);
	endtask

	// ---------------------------------------------------------------- tests

	// boundaries of the one, two and three byte forms
	task automatic test_code_point_edges();
		send_unit(16'h0001);
		send_unit(16'h007F);
		send_unit(16'h0080);
		send_unit(16'h07FF);
		send_unit(16'h0800);
		send_unit(16'hD7FF);
		send_unit(16'hE000);
		send_unit(16'hFFFF);
		send_unit(16'h0000);
	endtask

	// pairs, lone surrogates, back-to-back highs and flush on terminator
	task automatic test_surrogate_handling();
		send_unit(16'hD800);
		send_unit(16'hDC00);
		send_unit(16'hDBFF);
		send_unit(16'hDFFF);
		// lone high followed by a three-byte unit gives six words
		send_unit(16'hDBFF);
		send_unit(16'hFFFF);
		send_unit(16'hD800);
		send_unit(16'h0041);
		send_unit(16'hDC00);
		send_unit(16'hDFFF);
		send_unit(16'hD812);
		send_unit(16'hDBC0);
		send_unit(16'hDC01);
		send_unit(16'hDABC);
		send_unit(16'h0000);
		send_unit(16'h0000);
	endtask

	// mostly well-formed strings with random characters, some stray surrogates
	task automatic test_random_text(input int n_units);
		int          sent;
		int          kind;
		logic [15:0] cu;
		logic [19:0] offset;
		sent = 0;
		while (sent < n_units) begin
			kind = $urandom_range(99);
			if (kind < 18) begin
				cu = 16'($urandom_range(16'h007F, 16'h0001));
			end else if (kind < 36) begin
				cu = 16'($urandom_range(16'h07FF, 16'h0080));
			end else if (kind < 60) begin
				cu = 16'($urandom_range(16'hFFFF, 16'h0800));
				if (cu[15:11] == 5'b11011) cu = 16'($urandom_range(16'hFFFF, 16'hE000));
			end else if (kind < 82) begin
				// supplementary character as a surrogate pair
				offset = 20'($urandom);
				send_unit({u16u8_pkg::HighTag, offset[19:10]});
				sent++;
				cu = {u16u8_pkg::LowTag, offset[9:0]};
			end else if (kind < 88) begin
				cu = {u16u8_pkg::HighTag, 10'($urandom)};
			end else if (kind < 93) begin
				cu = {u16u8_pkg::LowTag, 10'($urandom)};
			end else begin
				cu = 16'h0000;
			end
			send_unit(cu);
			sent++;
		end
		send_unit(16'h0000);
	endtask

	// output held off while input keeps coming, so the queue fills
	task automatic test_output_stall();
		int i;
		hold_start = 1'b1;
		for (i = 0; i < 16; i++)
			send_unit(16'($urandom_range(16'hD7FF, 16'h0800)));
		send_unit(16'h0000);
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = 16'h0000;
		held_bits     = '0;
		held_ok       = 1'b0;
		fail_count    = 0;
		hold_start    = 1'b0;
		send_idle_pct = 0;
		recv_idle_pct = 0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		send_idle_pct = 28;
		recv_idle_pct = 83;
		test_code_point_edges();
		test_surrogate_handling();
		test_random_text(30);

		send_idle_pct = 83;
		recv_idle_pct = 28;
		test_random_text(30);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_output_stall();
		test_random_text(25);
		s_axis_tvalid <= 1'b0;

		// let every expected word arrive, then watch for strays
		while (utf8_expected.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);
		if (fail_count == 0) begin
			$display("== PASS ==");
		end else begin
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
